// ----- rtl/bsfc_pkg.sv -----
package bsfc_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned MaxRes  = 5;
    localparam int unsigned CountW  = 3;
    localparam int unsigned CfgIdxW = 2;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] REG_FLAG     = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_ESCAPE   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_ESC_FLAG = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_ESC_ESC  = 2'd3;

    localparam logic [ByteW-1:0] FLAG_RESET     = 8'h7E;
    localparam logic [ByteW-1:0] ESCAPE_RESET   = 8'h7D;
    localparam logic [ByteW-1:0] ESC_FLAG_RESET = 8'h5E;
    localparam logic [ByteW-1:0] ESC_ESC_RESET  = 8'h5D;

    // Operation codes carried in func.
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef struct packed {
        logic             func;
        logic [ByteW-1:0] in_byte;
        logic             message_last;
    } t_in_word;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             frame_end;
        logic             run_last;
    } t_out_word;

    typedef struct packed {
        logic [ByteW-1:0] flag_byte;
        logic [ByteW-1:0] escape_byte;
        logic [ByteW-1:0] escaped_flag_code;
        logic [ByteW-1:0] escaped_escape_code;
    } t_cfg;

    // One classified item: the run of result bytes it causes, in order.
    typedef struct packed {
        logic [CountW-1:0]             count;
        logic                          frame_end;
        logic [MaxRes-1:0][ByteW-1:0]  bytes;
    } t_job;

endpackage

// ----- rtl/bsfc_front.sv -----
module bsfc_front
    import bsfc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  logic     i_full,
    input  t_in_word i_word,
    output logic     o_stall,
    output logic     o_push,
    output t_job     o_job
);

    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_DATA = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;

    localparam logic [ByteW-1:0] TERMINATOR = 8'h00;

    logic       r_enc_in_frame;
    logic       n_enc_in_frame;
    logic [1:0] r_dec_mode;
    logic [1:0] n_dec_mode;
    t_job       job;
    logic       accept;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept && (job.count != '0);
    assign o_job   = job;

    always_comb begin
        job            = '0;
        n_enc_in_frame = r_enc_in_frame;
        n_dec_mode     = r_dec_mode;
        if (i_word.func == FUNC_ENCODE) begin
            if (!r_enc_in_frame) begin
                job.bytes[job.count] = i_cfg.flag_byte;
                job.count            = job.count + 3'd1;
                n_enc_in_frame       = 1'b1;
            end
            // A byte equal to both flag and escape is stuffed as an escape.
            if (i_word.in_byte == i_cfg.escape_byte) begin
                job.bytes[job.count] = i_cfg.escape_byte;
                job.count            = job.count + 3'd1;
                job.bytes[job.count] = i_cfg.escaped_escape_code;
                job.count            = job.count + 3'd1;
            end else if (i_word.in_byte == i_cfg.flag_byte) begin
                job.bytes[job.count] = i_cfg.escape_byte;
                job.count            = job.count + 3'd1;
                job.bytes[job.count] = i_cfg.escaped_flag_code;
                job.count            = job.count + 3'd1;
            end else begin
                job.bytes[job.count] = i_word.in_byte;
                job.count            = job.count + 3'd1;
            end
            if (i_word.message_last) begin
                job.bytes[job.count] = TERMINATOR;
                job.count            = job.count + 3'd1;
                job.bytes[job.count] = i_cfg.flag_byte;
                job.count            = job.count + 3'd1;
                n_enc_in_frame       = 1'b0;
            end
        end else begin
            unique case (r_dec_mode)
                MODE_DATA: begin
                    if (i_word.in_byte == i_cfg.flag_byte) begin
                        job.count     = 3'd1;
                        job.frame_end = 1'b1;
                        n_dec_mode    = MODE_HUNT;
                    end else if (i_word.in_byte == i_cfg.escape_byte) begin
                        n_dec_mode = MODE_ESC;
                    end else begin
                        job.count    = 3'd1;
                        job.bytes[0] = i_word.in_byte;
                    end
                end
                MODE_ESC: begin
                    job.count = 3'd1;
                    if (i_word.in_byte == i_cfg.flag_byte) begin
                        // The pending escape is dropped at the closing flag.
                        job.frame_end = 1'b1;
                        n_dec_mode    = MODE_HUNT;
                    end else begin
                        job.bytes[0] = (i_word.in_byte == i_cfg.escaped_flag_code) ?
                                       i_cfg.flag_byte : i_cfg.escape_byte;
                        n_dec_mode   = MODE_DATA;
                    end
                end
                default: begin
                    n_dec_mode = (i_word.in_byte == i_cfg.flag_byte) ? MODE_DATA : MODE_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc_in_frame <= 1'b0;
            r_dec_mode     <= MODE_HUNT;
        end else if (accept) begin
            r_enc_in_frame <= n_enc_in_frame;
            r_dec_mode     <= n_dec_mode;
        end
    end

endmodule

// ----- rtl/bsfc_queue.sv -----
module bsfc_queue
    import bsfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job       r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/bsfc_back.sv -----
module bsfc_back
    import bsfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_q_job,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    t_job              r_job;
    logic              r_busy;
    logic [CountW-1:0] r_idx;
    logic              r_out_valid;
    t_out_word         r_out_word;
    logic              out_free;
    logic              emit;
    logic              emit_last;

    assign out_free  = !r_out_valid || !i_stall;
    assign emit      = r_busy && out_free;
    assign emit_last = emit && (r_idx == (r_job.count - 3'd1));
    assign o_pop     = i_q_valid && (!r_busy || emit_last);
    assign o_valid   = r_out_valid;
    assign o_word    = r_out_word;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (emit) begin
            r_out_word.out_byte  <= r_job.bytes[r_idx];
            r_out_word.frame_end <= r_job.frame_end;
            r_out_word.run_last  <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= emit;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit_last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

endmodule

// ----- rtl/byte_stuffing_frame_codec.sv -----
// Byte-stuffing framer and deframer. Each input word is either a message byte to frame
// (func encode) or a line byte to deframe (func decode); the two directions keep separate
// state and may be interleaved freely. An input word causes between zero and five output
// words, and the last word of each run carries run_last. The output port sends one word per
// cycle while not stalled; an item gives one word for plain data, up to five for a stuffed
// byte that opens and closes a message. Decoder words that produce nothing (hunting, or a
// pending escape) are taken at one per cycle unless the queue is full. A word accepted into
// an empty block passes through the queue, the job register and the output register. A
// two-entry queue sits between the classifier and the output serialiser, so input is still
// taken while a finished word waits on a stalled output. The four code registers reset to
// the usual HDLC-style values and may only be written while the block is idle.
module byte_stuffing_frame_codec
    import bsfc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_word           i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_word          o_out_word,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [ByteW-1:0]   i_cfg_data
);

    t_cfg r_cfg;
    logic q_full;
    logic q_valid;
    logic q_push;
    logic q_pop;
    t_job front_job;
    t_job q_job;

    // Code registers, written through the plain configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte           <= FLAG_RESET;
            r_cfg.escape_byte         <= ESCAPE_RESET;
            r_cfg.escaped_flag_code   <= ESC_FLAG_RESET;
            r_cfg.escaped_escape_code <= ESC_ESC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FLAG:     r_cfg.flag_byte           <= i_cfg_data;
                REG_ESCAPE:   r_cfg.escape_byte         <= i_cfg_data;
                REG_ESC_FLAG: r_cfg.escaped_flag_code   <= i_cfg_data;
                REG_ESC_ESC:  r_cfg.escaped_escape_code <= i_cfg_data;
                default:      r_cfg                     <= r_cfg;
            endcase
        end
    end

    // The front end classifies each word and keeps the framer and deframer state.
    bsfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_full  (q_full),
        .i_word  (i_in_word),
        .o_stall (o_in_stall),
        .o_push  (q_push),
        .o_job   (front_job)
    );

    bsfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // The back end sends the queued runs out one word per cycle while the output is not stalled.
    bsfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_word    (o_out_word)
    );

endmodule
